// ===== design/lrupr_pkg.sv =====
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared types and fixed widths for the LRU page replacement block.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  localparam int PAGE_W  = 16;
  localparam int COUNT_W = 16;
  localparam int CFG_W   = 7;

  localparam logic [COUNT_W-1:0] MISS_MAX = {COUNT_W{1'b1}};
  localparam logic [CFG_W-1:0]   FRAMES_IN_USE_RST = CFG_W'(64);

  typedef struct packed {
    logic              hit;
    logic              evicted_valid;
    logic [PAGE_W-1:0] evicted_page;
  } lookup_t;

endpackage

// ===== design/lrupr_if.sv =====
// ----------------------------------------------------------------------------
// lrupr_req_if / lrupr_rsp_if
// Valid/ready channels for page references and replacement results.
// ----------------------------------------------------------------------------
interface lrupr_req_if import lrupr_pkg::*;;
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

interface lrupr_rsp_if import lrupr_pkg::*;;
  logic               valid;
  logic               ready;
  logic               hit;
  logic               evicted_valid;
  logic [PAGE_W-1:0]  evicted_page;
  logic [COUNT_W-1:0] miss_count;

  modport source (output valid, output hit, output evicted_valid, output evicted_page,
                  output miss_count, input ready);
  modport sink   (input valid, input hit, input evicted_valid, input evicted_page,
                  input miss_count, output ready);
endinterface

// ===== design/lrupr_store.sv =====
// ----------------------------------------------------------------------------
// lrupr_store
// Resident page row in recency order: parallel match, removal shift, append.
// ----------------------------------------------------------------------------
module lrupr_store import lrupr_pkg::*; #(
  parameter int FRAMES    = 64,
  parameter int PAGE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 update,
  input  logic [CFG_W-1:0]     frames_in_use,
  input  logic [PAGE_BITS-1:0] page,
  output lookup_t              look
);

  localparam int OCC_W = $clog2(FRAMES + 1);
  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int LIM_W = ((OCC_W > CFG_W) ? OCC_W : CFG_W) + 1;

  logic [PAGE_BITS-1:0]        pages      [FRAMES];
  logic [PAGE_BITS-1:0]        pages_up   [FRAMES];
  logic [PAGE_BITS-1:0]        pages_next [FRAMES];
  logic [OCC_W-1:0]            occupancy;
  logic [OCC_W-1:0]            occ_rm;
  logic [FRAMES-1:0]           match;
  logic [FRAMES-1:0]           shift;
  logic [IDX_W-1:0]            pos;
  logic [LIM_W-1:0]            limit;
  logic                        found;
  logic                        evict;
  logic [PAGE_BITS+PAGE_W-1:0] ev_ext;

  for (genvar g = 0; g < FRAMES; g++) begin : g_up
    if (g < FRAMES - 1) begin : g_mid
      assign pages_up[g] = pages[g+1];
    end else begin : g_last
      assign pages_up[g] = pages[g];
    end
  end

  always_comb begin
    if (frames_in_use == '0) begin
      limit = LIM_W'(1);
    end else if (LIM_W'(frames_in_use) > LIM_W'(FRAMES)) begin
      limit = LIM_W'(FRAMES);
    end else begin
      limit = LIM_W'(frames_in_use);
    end
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < FRAMES; i++) begin
      match[i] = (OCC_W'(i) < occupancy) && (pages[i] == page);
      if (match[i]) begin
        pos = pos | IDX_W'(i);
      end
    end
    found  = |match;
    evict  = !found && (LIM_W'(occupancy) >= limit);
    occ_rm = occupancy - OCC_W'(found || evict);
    for (int i = 0; i < FRAMES; i++) begin
      shift[i] = found ? (IDX_W'(i) >= pos) : evict;
      if (OCC_W'(i) == occ_rm) begin
        pages_next[i] = page;
      end else if (shift[i]) begin
        pages_next[i] = pages_up[i];
      end else begin
        pages_next[i] = pages[i];
      end
    end
  end

  assign ev_ext = {PAGE_W'(0), pages[0]};

  always_comb begin
    look.hit           = found;
    look.evicted_valid = evict;
    look.evicted_page  = evict ? ev_ext[PAGE_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (update) begin
      occupancy <= occ_rm + OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      for (int i = 0; i < FRAMES; i++) begin
        pages[i] <= pages_next[i];
      end
    end
  end

endmodule

// ===== design/lru_page_replacement.sv =====
// An accepted reference is held in the input register, and its result
// in the result register. Throughput: one reference per cycle while the
// result channel is not stalled; the match over all frames, the recency
// shift and the append are combinational between the input register and
// the result register. Reset: store empty, miss count zero, frames_in_use back to 64.
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative LRU page store with eviction report and fault counter.
// ----------------------------------------------------------------------------
module lru_page_replacement import lrupr_pkg::*; #(
  parameter int FRAMES    = 64,
  parameter int PAGE_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  lrupr_req_if.sink        req,
  lrupr_rsp_if.source      rsp
);

  logic                        s1_valid;
  logic [PAGE_BITS-1:0]        s1_page;
  logic [PAGE_BITS+PAGE_W-1:0] page_ext;
  logic [CFG_W-1:0]            frames_in_use;
  logic [COUNT_W-1:0]          miss_count;
  logic [COUNT_W-1:0]          miss_count_next;
  logic                        advance;
  lookup_t                     look;

  logic                        rsp_valid;
  logic                        rsp_hit;
  logic                        rsp_evicted_valid;
  logic [PAGE_W-1:0]           rsp_evicted_page;
  logic [COUNT_W-1:0]          rsp_miss_count;

  assign page_ext  = {PAGE_BITS'(0), req.page_number};
  assign advance   = s1_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_IN_USE_RST;
    end else if (cfg_we) begin
      frames_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_page <= page_ext[PAGE_BITS-1:0];
    end
  end

  lrupr_store #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_store (
    .clk           (clk),
    .rst           (rst),
    .update        (advance),
    .frames_in_use (frames_in_use),
    .page          (s1_page),
    .look          (look)
  );

  always_comb begin
    if (look.hit || (miss_count == MISS_MAX)) begin
      miss_count_next = miss_count;
    end else begin
      miss_count_next = miss_count + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      miss_count <= '0;
    end else if (advance) begin
      miss_count <= miss_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_hit           <= look.hit;
      rsp_evicted_valid <= look.evicted_valid;
      rsp_evicted_page  <= look.evicted_page;
      rsp_miss_count    <= miss_count_next;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.hit           = rsp_hit;
  assign rsp.evicted_valid = rsp_evicted_valid;
  assign rsp.evicted_page  = rsp_evicted_page;
  assign rsp.miss_count    = rsp_miss_count;

`ifndef NO_ASSERTIONS
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    advance |-> !(look.hit && look.evicted_valid))
    else $error("eviction reported on a hit");

  a_miss_counts: assert property (@(posedge clk) disable iff (rst)
    (advance && !look.hit) |=>
      ((miss_count == $past(miss_count) + COUNT_W'(1)) || ($past(miss_count) == MISS_MAX)))
    else $error("miss did not advance the fault counter");

  a_stage_drains: assert property (@(posedge clk) disable iff (rst)
    (advance && !(req.valid && req.ready)) |=> !s1_valid)
    else $error("input stage kept an item after it moved on");
`endif

endmodule

// ===== verif/lrupr_checker.sv =====
// ----------------------------------------------------------------------------
// lrupr_checker
// Watches the reference and result channels of the LRU page replacement
// block, keeps its own recency-ordered copy of the resident pages, the fault
// count and the frame limit, and compares every result item field by field
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module lrupr_checker import lrupr_pkg::*; #(
  parameter int FRAMES = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  lrupr_req_if             req,
  lrupr_rsp_if             rsp,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    lookup_t            lk;
    logic [COUNT_W-1:0] misses;
  } outcome_t;

  logic [PAGE_W-1:0]  resident [FRAMES];
  int                 occ;
  logic [COUNT_W-1:0] faults;
  logic [CFG_W-1:0]   frames_cfg;
  outcome_t           outcome_q [$];
  outcome_t           want;
  int                 n_err;

  initial begin
    n_err = 0;
  end

  function automatic int frame_limit();
    int lim;
    lim = int'(frames_cfg);
    if (lim < 1) lim = 1;
    if (lim > FRAMES) lim = FRAMES;
    return lim;
  endfunction

  function automatic void drop_entry(input int pos);
    for (int i = pos; i < occ - 1; i++) resident[i] = resident[i + 1];
    occ--;
  endfunction

  function automatic outcome_t predict_reference(input logic [PAGE_W-1:0] pg);
    outcome_t o;
    int       pos;
    pos = -1;
    o   = '0;
    for (int i = 0; i < occ; i++) begin
      if (pos < 0 && resident[i] == pg) pos = i;
    end
    if (pos >= 0) begin
      o.lk.hit = 1'b1;
      drop_entry(pos);
    end else begin
      if (faults != MISS_MAX) faults++;
      if (occ >= frame_limit()) begin
        o.lk.evicted_valid = 1'b1;
        o.lk.evicted_page  = resident[0];
        drop_entry(0);
      end
    end
    if (occ < FRAMES) begin
      resident[occ] = pg;
      occ++;
    end
    o.misses = faults;
    return o;
  endfunction

  function automatic void check_field(input string what, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, exp_v, act_v);
      n_err++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      occ        = 0;
      faults     = '0;
      frames_cfg = FRAMES_IN_USE_RST;
      outcome_q.delete();
    end else begin
      if (cfg_we) frames_cfg = cfg_data;
      if (rsp.valid && rsp.ready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result item, expected none actual %0b %0b %0h %0h",
                   $time, rsp.hit, rsp.evicted_valid, rsp.evicted_page, rsp.miss_count);
          n_err++;
        end else begin
          want = outcome_q[0];
          outcome_q.delete(0);
          check_field("hit", 32'(want.lk.hit), 32'(rsp.hit));
          check_field("evicted_valid", 32'(want.lk.evicted_valid), 32'(rsp.evicted_valid));
          check_field("evicted_page", 32'(want.lk.evicted_page), 32'(rsp.evicted_page));
          check_field("miss_count", 32'(want.misses), 32'(rsp.miss_count));
        end
      end
      if (req.valid && req.ready)
        outcome_q.insert(outcome_q.size(), predict_reference(req.page_number));
    end
    errors  <= n_err;
    pending <= outcome_q.size();
  end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives page references into the LRU page replacement block through a short
// directed sequence and random phases over a range of frame limits and
// working sets, with random stalls on both channels. The checker predicts
// and compares each result.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lrupr_pkg::*;

  localparam int FRAMES     = 64;
  localparam int IDLE_LIMIT = 1000;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;
  int               errors;
  int               pending;
  int               stall_pct = 0;
  bit               quiet = 1'b0;
  int               idle_cycles = 0;

  lrupr_req_if req_ch ();
  lrupr_rsp_if rsp_ch ();

  always #5 clk = ~clk;

  lru_page_replacement #(.FRAMES(FRAMES), .PAGE_BITS(PAGE_W)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  lrupr_checker #(.FRAMES(FRAMES)) checker_i (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .errors   (errors),
    .pending  (pending)
  );

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("testbench: errors");
    $finish;
  end

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  task automatic send_page(input logic [PAGE_W-1:0] pg);
    if (!quiet && $urandom_range(0, 99) < stall_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.page_number <= pg;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // hold off until every outstanding result has come back
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int                count;
    int                lim;
    int                ws;
    int                n;
    int unsigned       base;
    logic [PAGE_W-1:0] pg;
    logic [CFG_W-1:0]  fr;

    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_data           = '0;
    req_ch.valid       = 1'b0;
    req_ch.page_number = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    stall_pct = 30;
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h0000);
    send_page(16'hFFFF);
    write_frames(CFG_W'(3));
    send_page(16'h0001);
    send_page(16'h0002);
    send_page(16'hFFFF);
    send_page(16'h0003);
    send_page(16'hAAAA);
    send_page(16'h5555);
    // limit below occupancy: residents still hit, one eviction per fault
    write_frames(CFG_W'(1));
    send_page(16'h0003);
    send_page(16'h8000);
    send_page(16'h5555);
    send_page(16'h0001);
    write_frames(CFG_W'(0));
    send_page(16'h7FFF);
    send_page(16'h0002);
    send_page(16'h7FFF);
    write_frames(CFG_W'(127));
    for (int i = 0; i < 5; i++) send_page(PAGE_W'(16'h1000 + i));
    write_frames(CFG_W'(65));
    send_page(16'h1000);

    count = 0;
    while (count < 1100) begin
      quiet = (count >= 900);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 10;
        2: stall_pct = 30;
        default: stall_pct = 60;
      endcase
      case ($urandom_range(0, 7))
        0: fr = CFG_W'(1);
        1: fr = CFG_W'(64);
        2: fr = CFG_W'(0);
        3: fr = CFG_W'(127);
        4: fr = CFG_W'($urandom_range(2, 8));
        5: fr = CFG_W'($urandom_range(60, 70));
        default: fr = CFG_W'($urandom_range(1, 64));
      endcase
      write_frames(fr);
      lim  = (fr == 0) ? 1 : ((fr > FRAMES) ? FRAMES : int'(fr));
      ws   = $urandom_range(1, lim + 8);
      base = $urandom;
      n    = $urandom_range(40, 120);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) pg = PAGE_W'($urandom);
        else pg = PAGE_W'(base + $urandom_range(0, ws - 1));
        send_page(pg);
        count++;
        if ($urandom_range(0, 199) == 0) drain();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/lrupr_pkg.sv
design/lrupr_if.sv
design/lrupr_store.sv
design/lru_page_replacement.sv
verif/lrupr_checker.sv
verif/testbench.sv
